// ----- design/epr_pkg.sv -----
// Package: item types, register indexes and constants for the echo pulse ranger.
`timescale 1ns / 1ps

package epr_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int CAPTURE_W        = 16;
    localparam int SCALE_W          = 12;
    localparam int DIST_W           = 28;
    localparam int TIMEOUT_W        = 8;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 28;

    localparam logic [SCALE_W-1:0]   SCALE_RST   = 12'd1360;
    localparam logic [DIST_W-1:0]    MAX_RNG_RST = 28'd6000000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd20;
    localparam logic [TIMEOUT_W-1:0] MISS_MAX    = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE   = 2'd0,
        CFG_MAX_RNG = 2'd1,
        CFG_TIMEOUT = 2'd2
    } t_cfg_idx;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_CAPTURE = 1'b1;

    typedef struct packed {
        logic                 opcode;
        logic [CAPTURE_W-1:0] capture_count;
    } t_in_item;

    typedef struct packed {
        logic              published;
        logic [DIST_W-1:0] distance_um;
        logic              trigger;
    } t_out_item;

endpackage

// ----- design/echo_pulse_ranger.sv -----
// Top level: echo capture pairing, poll tick handling and result register.
// A poll tick's result goes from the input register to the result register; a held result can stall it between them.
// Throughput: one item per cycle; a tick waits while a result is held, a capture does not.
// Path: input register, one 16x12 multiply and range compare, result register.
// Reset (synchronous, active low): expect rising edge, no reading, miss count 0,
// registers at 1360 um/count, 6000000 um range, 20 tick timeout.
`timescale 1ns / 1ps

module echo_pulse_ranger #(
    parameter int COUNTER_BITS = epr_pkg::COUNTER_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  epr_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output epr_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [epr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [epr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [epr_pkg::SCALE_W-1:0]   r_scale;
    logic [epr_pkg::DIST_W-1:0]    r_max_range;
    logic [epr_pkg::TIMEOUT_W-1:0] r_timeout;

    logic                          r_in_valid;
    epr_pkg::t_in_item             r_in;
    logic                          r_out_valid;
    epr_pkg::t_out_item            r_out;

    logic                          r_expect_rising, n_expect_rising;
    logic                          r_reading_done, n_reading_done;
    logic [COUNTER_BITS-1:0]       r_start_count, n_start_count;
    logic [COUNTER_BITS-1:0]       r_end_count, n_end_count;
    logic [epr_pkg::TIMEOUT_W-1:0] r_miss_ticks, n_miss_ticks;
    epr_pkg::t_out_item            n_out;

    logic                          adv;
    logic                          in_acc;
    logic [epr_pkg::DIST_W-1:0]    tick_dist;
    logic [epr_pkg::TIMEOUT_W-1:0] miss_inc;

    assign o_cfg_ready = 1'b1;
    assign adv = r_in_valid
        && (r_in.opcode == epr_pkg::OP_CAPTURE || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= epr_pkg::SCALE_RST;
            r_max_range <= epr_pkg::MAX_RNG_RST;
            r_timeout   <= epr_pkg::TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                epr_pkg::CFG_SCALE:   r_scale     <= i_cfg_data[epr_pkg::SCALE_W-1:0];
                epr_pkg::CFG_MAX_RNG: r_max_range <= i_cfg_data[epr_pkg::DIST_W-1:0];
                epr_pkg::CFG_TIMEOUT: r_timeout   <= i_cfg_data[epr_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    epr_dist #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dist (
        .i_start_count (r_start_count),
        .i_end_count   (r_end_count),
        .i_scale       (r_scale),
        .i_max_range   (r_max_range),
        .o_distance_um (tick_dist)
    );

    always_comb begin
        n_expect_rising = r_expect_rising;
        n_reading_done  = r_reading_done;
        n_start_count   = r_start_count;
        n_end_count     = r_end_count;
        n_miss_ticks    = r_miss_ticks;
        n_out           = '0;
        miss_inc = (r_miss_ticks < epr_pkg::MISS_MAX) ? r_miss_ticks + 1'b1 : r_miss_ticks;
        if (r_in.opcode == epr_pkg::OP_CAPTURE) begin
            if (r_expect_rising) begin
                n_start_count   = COUNTER_BITS'(r_in.capture_count);
                n_expect_rising = 1'b0;
            end else begin
                n_end_count     = COUNTER_BITS'(r_in.capture_count);
                n_reading_done  = 1'b1;
                n_expect_rising = 1'b1;
                n_miss_ticks    = '0;
            end
        end else begin
            if (r_reading_done) begin
                n_out.published   = 1'b1;
                n_out.distance_um = tick_dist;
                n_out.trigger     = 1'b1;
                n_reading_done    = 1'b0;
                n_expect_rising   = 1'b1;
            end
            n_miss_ticks = miss_inc;
            if (miss_inc > r_timeout) begin
                n_reading_done  = 1'b0;
                n_expect_rising = 1'b1;
                n_out.trigger   = 1'b1;
                n_miss_ticks    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_expect_rising <= 1'b1;
            r_reading_done  <= 1'b0;
            r_start_count   <= '0;
            r_end_count     <= '0;
            r_miss_ticks    <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_expect_rising <= n_expect_rising;
                r_reading_done  <= n_reading_done;
                r_start_count   <= n_start_count;
                r_end_count     <= n_end_count;
                r_miss_ticks    <= n_miss_ticks;
            end
            if (adv && r_in.opcode == epr_pkg::OP_TICK) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_item;
        end
        if (adv && r_in.opcode == epr_pkg::OP_TICK) begin
            r_out <= n_out;
        end
    end

    a_pub_trig : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.published |-> r_out.trigger)
        else $error("published result without trigger");

    a_idle_dist : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.published |-> r_out.distance_um == '0)
        else $error("unpublished result carries a distance");

    a_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.distance_um <= r_max_range)
        else $error("distance above range limit");

    a_cap_no_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.opcode == epr_pkg::OP_CAPTURE && !r_out_valid |=> !r_out_valid)
        else $error("capture produced a result");

    a_tick_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.opcode == epr_pkg::OP_TICK |=> !r_reading_done && r_expect_rising
            || !$past(r_reading_done) && $past(r_expect_rising) == r_expect_rising)
        else $error("tick left a reading pending");

endmodule

// ----- design/epr_dist.sv -----
// Distance unit: wrapped pulse length times scale, zeroed above the range limit.
`timescale 1ns / 1ps

module epr_dist #(
    parameter int COUNTER_BITS = epr_pkg::COUNTER_BITS_DEF
) (
    input  logic [COUNTER_BITS-1:0]     i_start_count,
    input  logic [COUNTER_BITS-1:0]     i_end_count,
    input  logic [epr_pkg::SCALE_W-1:0] i_scale,
    input  logic [epr_pkg::DIST_W-1:0]  i_max_range,
    output logic [epr_pkg::DIST_W-1:0]  o_distance_um
);

    localparam int PROD_W = COUNTER_BITS + epr_pkg::SCALE_W;
    localparam int CMP_W  = (PROD_W > epr_pkg::DIST_W) ? PROD_W : epr_pkg::DIST_W;

    logic [COUNTER_BITS-1:0] len;
    logic [PROD_W-1:0]       prod;
    logic                    over;

    always_comb begin
        len  = i_end_count - i_start_count;
        prod = PROD_W'(len) * PROD_W'(i_scale);
        over = CMP_W'(prod) > CMP_W'(i_max_range);
        o_distance_um = over ? '0 : epr_pkg::DIST_W'(prod);
    end

endmodule
